// ----- rtl/core/waveform_sample_generator_defines.svh -----
// Assertion macros for the waveform sample generator RTL.
// Included by modules that carry concurrent checks; needs clk and rst in scope.
`ifndef WAVEFORM_SAMPLE_GENERATOR_DEFINES_SVH
`define WAVEFORM_SAMPLE_GENERATOR_DEFINES_SVH
`ifndef SYNTHESIS
// Check that is off while reset is high.
`define WSG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check that also runs through reset.
`define WSG_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define WSG_ASSERT(lbl, prop, msg)
`define WSG_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ----- rtl/core/wsg_pkg.sv -----
// Shared types, constants and the quarter-wave sine table of the waveform
// sample generator. No dependencies.
package wsg_pkg;

  localparam int PHASE_BITS     = 32;
  localparam int SINE_ADDR_BITS = 10;
  localparam int QTR_SIZE       = 1 << (SINE_ADDR_BITS - 2);
  localparam int REG_W          = 32;
  localparam int ADDR_W         = 4;
  localparam int SHAPE_W        = 2;
  localparam int AMP_W          = 15;
  localparam int SAMPLE_W       = 16;
  localparam int VAL_W          = 18;   // shape value, -65536..65536
  localparam int QVAL_W         = 17;   // quarter sine, 0..65536
  localparam int PROD_W         = 34;
  localparam int Q16_ONE        = 1 << 16;

  localparam longint unsigned MIDSCALE = 64'd32767;
  localparam longint unsigned POLY_A   = 64'd102944;
  localparam longint unsigned POLY_B   = 64'd42048;
  localparam longint unsigned POLY_C   = 64'd4640;

  typedef enum logic [SHAPE_W-1:0] {
    SHAPE_SINE     = 2'd0,
    SHAPE_SQUARE   = 2'd1,
    SHAPE_TRIANGLE = 2'd2
  } shape_t;

  typedef enum logic [1:0] {
    REG_SHAPE     = 2'd0,
    REG_INCREMENT = 2'd1,
    REG_START     = 2'd2,
    REG_AMPLITUDE = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [SHAPE_W-1:0]    shape;
    logic [PHASE_BITS-1:0] increment;  // aligned to the accumulator
    logic [PHASE_BITS-1:0] start;      // aligned to the accumulator
    logic [AMP_W-1:0]      amplitude;
  } cfg_t;

  // Points below the quarter cycle; the quarter-cycle point is the exact peak.
  typedef logic [QVAL_W-1:0] qtab_t [0:QTR_SIZE-1];

  // Scale a 32-bit cycle fraction to the accumulator width.
  function automatic logic [PHASE_BITS-1:0] align_reg(input logic [REG_W-1:0] v);
    logic [PHASE_BITS+REG_W-1:0] wide;
    wide = {v, {PHASE_BITS{1'b0}}};
    return wide[PHASE_BITS+REG_W-1:REG_W];
  endfunction

  // Quarter-wave polynomial, evaluated at elaboration only.
  function automatic qtab_t build_qtab();
    qtab_t           tab;
    longint unsigned t;
    longint unsigned t2;
    longint unsigned p;
    for (int i = 0; i < QTR_SIZE; i++) begin
      t      = longint'(i) << (18 - SINE_ADDR_BITS);
      t2     = (t * t) >> 16;
      p      = POLY_B - ((POLY_C * t2) >> 16);
      p      = POLY_A - ((p * t2) >> 16);
      tab[i] = QVAL_W'((p * t) >> 16);
    end
    return tab;
  endfunction

  localparam qtab_t QTAB = build_qtab();

endpackage

// ----- rtl/core/wsg_regs.sv -----
// APB-style configuration registers of the waveform sample generator.
// Depends on wsg_pkg.
module wsg_regs
  import wsg_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [REG_W-1:0]  pwdata,
  output logic [REG_W-1:0]  prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic [SHAPE_W-1:0] shape;
  logic [REG_W-1:0]   increment;
  logic [REG_W-1:0]   start;
  logic [AMP_W-1:0]   amplitude;
  logic               wr_en;
  reg_idx_t           idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      shape     <= '0;
      increment <= '0;
      start     <= '0;
      amplitude <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_SHAPE:     shape     <= pwdata[SHAPE_W-1:0];
        REG_INCREMENT: increment <= pwdata;
        REG_START:     start     <= pwdata;
        REG_AMPLITUDE: amplitude <= pwdata[AMP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SHAPE:     prdata = {{(REG_W-SHAPE_W){1'b0}}, shape};
      REG_INCREMENT: prdata = increment;
      REG_START:     prdata = start;
      REG_AMPLITUDE: prdata = {{(REG_W-AMP_W){1'b0}}, amplitude};
      default:       prdata = '0;
    endcase
  end

  assign cfg.shape     = shape;
  assign cfg.increment = align_reg(increment);
  assign cfg.start     = align_reg(start);
  assign cfg.amplitude = amplitude;

endmodule

// ----- rtl/core/wsg_shape.sv -----
// Phase to signed Q16 shape value: sine table, square and triangle.
// Depends on wsg_pkg.
module wsg_shape
  import wsg_pkg::*;
(
  input  logic [SHAPE_W-1:0]    shape,
  input  logic [PHASE_BITS-1:0] phase,
  output logic signed [VAL_W-1:0] value
);

  logic [SINE_ADDR_BITS-1:0] k;
  logic [1:0]                quad;
  logic [SINE_ADDR_BITS-3:0] r;
  logic [SINE_ADDR_BITS-2:0] x;
  logic [QVAL_W-1:0]         qval;
  logic signed [VAL_W-1:0]   sine_val;
  logic [15:0]               h;
  logic [VAL_W-2:0]          tri_v;
  logic signed [VAL_W:0]     tri_val;

  // Quarter-wave symmetry: mirror odd quadrants, negate the second half.
  assign k    = phase[PHASE_BITS-1 -: SINE_ADDR_BITS];
  assign quad = k[SINE_ADDR_BITS-1 -: 2];
  assign r    = k[SINE_ADDR_BITS-3:0];
  assign x    = quad[0] ? ((SINE_ADDR_BITS-1)'(QTR_SIZE) - {1'b0, r}) : {1'b0, r};
  // Top bit of x marks the quarter-cycle point, which is the exact peak.
  assign qval = x[SINE_ADDR_BITS-2] ? QVAL_W'(Q16_ONE) : QTAB[x[SINE_ADDR_BITS-3:0]];
  assign sine_val = quad[1] ? -$signed({1'b0, qval}) : $signed({1'b0, qval});

  assign h       = phase[PHASE_BITS-1 -: 16];
  assign tri_v   = h[15] ? ((VAL_W-1)'(Q16_ONE) - {1'b0, h}) << 1 : {1'b0, h} << 1;
  assign tri_val = $signed({1'b0, tri_v, 1'b0}) - $signed((VAL_W+1)'(Q16_ONE));

  always_comb begin
    case (shape_t'(shape))
      SHAPE_SINE:     value = sine_val;
      SHAPE_SQUARE:   value = phase[PHASE_BITS-1] ? -$signed(VAL_W'(65536))
                                                  : $signed(VAL_W'(65536));
      SHAPE_TRIANGLE: value = tri_val[VAL_W-1:0];
      default:        value = '0;
    endcase
  end

endmodule

// ----- rtl/core/waveform_sample_generator.sv -----
// Waveform sample generator: phase accumulator, shape logic and sample scaling.
// Depends on wsg_pkg, wsg_regs, wsg_shape and the assertion macro header.
//
// Usage:
//   Request channel (in_valid / in_stall / restart): each transaction asks for
//   one sample. With restart high the phase first reloads from start_phase.
//   Sample channel (out_valid / out_stall / sample): one transaction per
//   request, in order, offset binary around 32767, always 0..65534.
//   Configuration goes through the APB-style port (wave_shape at 0x0,
//   phase_increment at 0x4, start_phase at 0x8, amplitude at 0xC); write it
//   only while no request is in flight.
// Throughput: one sample per clock while out_stall is low; the accumulator
//   add is the only loop.
// Pipeline: an accepted request passes the phase register, the shape register
//   and the output register, in that order.
// Reset: clears the accumulator, all configuration registers and every valid
//   bit; the first sample after reset starts at phase zero unless restart is high.
// Stall: a stalled sample holds in the output register; upstream stages keep
//   filling bubbles and in_stall rises only once every stage holds data.
`include "waveform_sample_generator_defines.svh"

module waveform_sample_generator
  import wsg_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [REG_W-1:0]    pwdata,
  output logic [REG_W-1:0]    prdata,
  output logic                pready,
  // request channel
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                restart,
  // sample channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic [SAMPLE_W-1:0] sample
);

  cfg_t                    cfg;
  logic [PHASE_BITS-1:0]   phase_acc;
  logic [PHASE_BITS-1:0]   cur_phase;
  logic                    in_accept;

  logic                    s1_valid;
  logic [PHASE_BITS-1:0]   s1_phase;
  logic                    s2_valid;
  logic signed [VAL_W-1:0] s2_value;
  logic signed [VAL_W-1:0] shape_value;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] total;

  logic                    out_adv;
  logic                    s2_adv;
  logic                    s1_adv;

  wsg_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Advance a stage when it is empty or its content moves on.
  assign out_adv   = !out_valid || !out_stall;
  assign s2_adv    = !s2_valid || out_adv;
  assign s1_adv    = !s1_valid || s2_adv;
  assign in_stall  = !s1_adv;
  assign in_accept = in_valid && !in_stall;

  // Reload on restart, then step by the increment with modular wrap.
  assign cur_phase = restart ? cfg.start : phase_acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_acc <= '0;
    end else if (in_accept) begin
      phase_acc <= cur_phase + cfg.increment;
    end
  end

  // Stage 1: hold the phase of this sample.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_adv) begin
      s1_valid <= in_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_phase <= cur_phase;
    end
  end

  wsg_shape u_shape (
    .shape (cfg.shape),
    .phase (s1_phase),
    .value (shape_value)
  );

  // Stage 2: hold the signed Q16 shape value.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_adv) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv && s1_valid) begin
      s2_value <= shape_value;
    end
  end

  // Scale by amplitude around midscale; total never goes negative, so the
  // floor of total / 2^16 is just its upper bits.
  assign prod  = PROD_W'($signed({1'b0, cfg.amplitude})) * PROD_W'(s2_value);
  assign total = prod + $signed(PROD_W'(MIDSCALE << 16));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_adv) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && s2_valid) begin
      sample <= total[31:16];
    end
  end

  `WSG_ASSERT(a_sample_range, out_valid |-> (sample <= 16'd65534), "sample above 65534")
  `WSG_ASSERT(a_accept_fills_s1, in_accept |=> s1_valid, "accepted request lost in stage 1")
  `WSG_ASSERT(a_restart_phase,
              (in_accept && restart) |=> (phase_acc == $past(cfg.start + cfg.increment)),
              "restart did not reload phase")
  `WSG_ASSERT(a_stall_only_full,
              in_stall |-> (s1_valid && s2_valid && out_valid),
              "request stalled with a free stage")
  `WSG_ASSERT_ALWAYS(a_reset_empty,
                     rst |=> (!out_valid && !s1_valid && !s2_valid),
                     "pipeline not empty after reset")

endmodule
